### sv/iodrb_pkg.sv
`default_nettype none

package iodrb_pkg;

    localparam int SEQ_BITS    = 16;
    localparam int WINDOW      = 32;
    localparam int HANDLE_BITS = 32;
    localparam int SLOT_BITS   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int KIND_BITS   = 3;

    localparam logic [KIND_BITS-1:0] KIND_UNREL  = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_DELIV  = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_DUP    = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_BUF    = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_BEYOND = 3'd4;

    typedef struct packed {
        logic capture;
        logic classify;
        logic drain;
    } iodrb_cmd_t;

    typedef struct packed {
        logic deliver;
        logic more;
    } iodrb_sts_t;

    function automatic logic [SLOT_BITS-1:0] slot_inc(
        input logic [SLOT_BITS-1:0] slot,
        input logic [SEQ_BITS-1:0]  new_seq
    );
        logic [SLOT_BITS-1:0] r;
        if (new_seq == '0)
        begin
            r = '0;
        end
        else if (slot == SLOT_BITS'(WINDOW - 1))
        begin
            r = '0;
        end
        else
        begin
            r = slot + 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/iodrb_ctrl.sv
`default_nettype none

module iodrb_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire iodrb_pkg::iodrb_sts_t sts,
    output iodrb_pkg::iodrb_cmd_t   cmd,
    output logic                    busy
);

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_CLASSIFY = 2'd1;
    localparam logic [1:0] ST_DRAIN    = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                state_next = (sts.deliver && sts.more) ? ST_DRAIN : ST_IDLE;
            end
            ST_DRAIN:
            begin
                state_next = sts.more ? ST_DRAIN : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.capture  = (state_reg == ST_IDLE) && start;
    assign cmd.classify = (state_reg == ST_CLASSIFY);
    assign cmd.drain    = (state_reg == ST_DRAIN);
    assign busy         = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

### sv/iodrb_dp.sv
`default_nettype none

module iodrb_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire iodrb_pkg::iodrb_cmd_t               cmd,
    output iodrb_pkg::iodrb_sts_t                    sts,
    input  wire logic                                reliable,
    input  wire logic [iodrb_pkg::SEQ_BITS-1:0]      seq_num,
    input  wire logic [iodrb_pkg::HANDLE_BITS-1:0]   payload_handle,
    output logic                                     strobe,
    output logic [iodrb_pkg::KIND_BITS-1:0]          kind,
    output logic [iodrb_pkg::HANDLE_BITS-1:0]        out_handle,
    output logic [iodrb_pkg::SEQ_BITS-1:0]           out_seq,
    output logic                                     last
);

    localparam int SB = iodrb_pkg::SEQ_BITS;
    localparam int LB = iodrb_pkg::SLOT_BITS;
    localparam int HB = iodrb_pkg::HANDLE_BITS;
    localparam int KB = iodrb_pkg::KIND_BITS;
    localparam int W  = iodrb_pkg::WINDOW;

    logic          rel_reg;
    logic [SB-1:0] seq_reg;
    logic [HB-1:0] hdl_reg;
    logic [SB-1:0] ld_reg;
    logic [LB-1:0] ldslot_reg;
    logic [W-1:0]  valid_reg;
    logic [HB-1:0] mem [W];
    logic [HB-1:0] rd_reg;

    logic          strobe_reg;
    logic [KB-1:0] kind_reg;
    logic [HB-1:0] ohdl_reg;
    logic [SB-1:0] oseq_reg;
    logic          last_reg;

    logic [SB-1:0] d;
    logic          is_dup;
    logic          is_del;
    logic          is_buf;
    logic [LB:0]   sum;
    logic [LB-1:0] seq_slot;
    logic [SB-1:0] cur_seq;
    logic [LB-1:0] cur_slot;
    logic [SB-1:0] fol_seq;
    logic [LB-1:0] fol_slot;
    logic          more;
    logic          buf_we;

    always_comb
    begin
        d      = seq_reg - ld_reg;
        is_dup = (d == '0) || d[SB-1];
        is_del = (d == SB'(1));
        is_buf = !is_dup && !is_del && (d <= SB'(W));
        sum    = {1'b0, ldslot_reg} + d[LB:0];
        if (sum >= (LB + 1)'(W))
        begin
            sum = sum - (LB + 1)'(W);
        end
        seq_slot = (seq_reg < d) ? seq_reg[LB-1:0] : sum[LB-1:0];

        if (cmd.classify)
        begin
            cur_seq  = seq_reg;
            cur_slot = seq_slot;
        end
        else
        begin
            cur_seq  = ld_reg + 1'b1;
            cur_slot = iodrb_pkg::slot_inc(ldslot_reg, cur_seq);
        end
        fol_seq  = cur_seq + 1'b1;
        fol_slot = iodrb_pkg::slot_inc(cur_slot, fol_seq);
        more     = valid_reg[fol_slot] && !(cmd.drain && (fol_slot == cur_slot));
        buf_we   = cmd.classify && rel_reg && is_buf;
    end

    assign sts.deliver = rel_reg && is_del;
    assign sts.more    = more;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rel_reg <= reliable;
            seq_reg <= seq_num;
            hdl_reg <= payload_handle;
        end
        if (buf_we)
        begin
            mem[seq_slot] <= hdl_reg;
        end
        rd_reg <= mem[fol_slot];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_reg     <= '0;
            ldslot_reg <= '0;
            valid_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.classify || cmd.drain;
            if (buf_we)
            begin
                valid_reg[seq_slot] <= 1'b1;
            end
            if ((cmd.classify && rel_reg && is_del) || cmd.drain)
            begin
                ld_reg     <= cur_seq;
                ldslot_reg <= cur_slot;
            end
            if (cmd.drain)
            begin
                valid_reg[cur_slot] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.classify)
        begin
            ohdl_reg <= hdl_reg;
            oseq_reg <= rel_reg ? seq_reg : '0;
            last_reg <= !(rel_reg && is_del && more);
            if (!rel_reg)
            begin
                kind_reg <= iodrb_pkg::KIND_UNREL;
            end
            else if (is_dup)
            begin
                kind_reg <= iodrb_pkg::KIND_DUP;
            end
            else if (is_del)
            begin
                kind_reg <= iodrb_pkg::KIND_DELIV;
            end
            else if (is_buf)
            begin
                kind_reg <= iodrb_pkg::KIND_BUF;
            end
            else
            begin
                kind_reg <= iodrb_pkg::KIND_BEYOND;
            end
        end
        else if (cmd.drain)
        begin
            kind_reg <= iodrb_pkg::KIND_DELIV;
            ohdl_reg <= rd_reg;
            oseq_reg <= cur_seq;
            last_reg <= !more;
        end
    end

    assign strobe     = strobe_reg;
    assign kind       = kind_reg;
    assign out_handle = ohdl_reg;
    assign out_seq    = oseq_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

### sv/in_order_delivery_reorder_buffer_core.sv
`default_nettype none
// Channel   Direction  Handshake           Signals
// request   in         start & !busy       reliable, seq_num, payload_handle
// result    out        strobe, one cycle   kind, out_handle, out_seq, last
//
// A request is taken while the block is idle and classified in the next cycle; its first
// result shows on the cycle after that. A delivery that releases parked entries goes on
// with one result per entry, each read through the registered read port of the slot memory.
// Reset clears the last delivered number and all slot valid bits at once.
// The receiver cannot stall; results are shown once and never held.

module in_order_delivery_reorder_buffer_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                reliable,
    input  wire logic [iodrb_pkg::SEQ_BITS-1:0]      seq_num,
    input  wire logic [iodrb_pkg::HANDLE_BITS-1:0]   payload_handle,
    output logic                                     strobe,
    output logic [iodrb_pkg::KIND_BITS-1:0]          kind,
    output logic [iodrb_pkg::HANDLE_BITS-1:0]        out_handle,
    output logic [iodrb_pkg::SEQ_BITS-1:0]           out_seq,
    output logic                                     last
);

    iodrb_pkg::iodrb_cmd_t cmd;
    iodrb_pkg::iodrb_sts_t sts;

    iodrb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    iodrb_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .reliable       (reliable),
        .seq_num        (seq_num),
        .payload_handle (payload_handle),
        .strobe         (strobe),
        .kind           (kind),
        .out_handle     (out_handle),
        .out_seq        (out_seq),
        .last           (last)
    );

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("result run broken before last");

    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("block idle during a result run");

    a_first_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> !strobe ##1 strobe)
        else $error("request result not shown two cycles after acceptance");

    a_drain_kind: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drain |=> strobe && (kind == iodrb_pkg::KIND_DELIV))
        else $error("drained entry not delivered");

endmodule

`default_nettype wire

### tb/sv/in_order_delivery_reorder_buffer_core_tb.sv
module in_order_delivery_reorder_buffer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB = iodrb_pkg::SEQ_BITS;
    localparam int HB = iodrb_pkg::HANDLE_BITS;
    localparam int KB = iodrb_pkg::KIND_BITS;
    localparam int W  = iodrb_pkg::WINDOW;

    typedef struct packed {
        logic [KB-1:0] kind;
        logic [HB-1:0] handle;
        logic [SB-1:0] seq;
        logic          last;
    } result_t;

    class delivery_scoreboard;
        logic [SB-1:0] last_seq;
        bit            slot_full [W];
        logic [HB-1:0] slot_data [W];
        result_t       batch [$];
        result_t       due_results [$];
        int            faults;
        int            requests;
        int            results_seen;
        int            longest_run;
        int            kind_tally [iodrb_pkg::KIND_BEYOND+1];

        function new();
            last_seq = '0;
            foreach (slot_full[i])
            begin
                slot_full[i] = 1'b0;
                slot_data[i] = '0;
            end
            foreach (kind_tally[i])
            begin
                kind_tally[i] = 0;
            end
            faults = 0;
            requests = 0;
            results_seen = 0;
            longest_run = 0;
        endfunction

        function void stage(input logic [KB-1:0] k, input logic [HB-1:0] h,
                            input logic [SB-1:0] s);
            result_t r;
            r.kind = k;
            r.handle = h;
            r.seq = s;
            r.last = 1'b0;
            batch = {batch, r};
        endfunction

        function void flag(input string what);
            faults++;
            if (faults <= 10)
            begin
                $display("%0t ns: %s", $time, what);
            end
        endfunction

        function void note_request(input logic rel, input logic [SB-1:0] sq,
                                   input logic [HB-1:0] h);
            logic [SB-1:0] ahead;
            logic [SB-1:0] nxt;
            int            slot;
            int            run;
            result_t       r;
            requests++;
            batch.delete();
            if (!rel)
            begin
                stage(iodrb_pkg::KIND_UNREL, h, '0);
            end
            else
            begin
                ahead = sq - last_seq;
                if (ahead == '0 || ahead[SB-1])
                begin
                    stage(iodrb_pkg::KIND_DUP, h, sq);
                end
                else if (ahead == 1)
                begin
                    stage(iodrb_pkg::KIND_DELIV, h, sq);
                    last_seq = sq;
                    run = 1;
                    nxt = last_seq + 1'b1;
                    slot = int'(nxt % W);
                    while (run < W && slot_full[slot])
                    begin
                        stage(iodrb_pkg::KIND_DELIV, slot_data[slot], nxt);
                        slot_full[slot] = 1'b0;
                        last_seq = nxt;
                        run++;
                        nxt = last_seq + 1'b1;
                        slot = int'(nxt % W);
                    end
                    if (run > longest_run)
                    begin
                        longest_run = run;
                    end
                end
                else if (ahead <= W)
                begin
                    slot = int'(sq % W);
                    slot_data[slot] = h;
                    slot_full[slot] = 1'b1;
                    stage(iodrb_pkg::KIND_BUF, h, sq);
                end
                else
                begin
                    stage(iodrb_pkg::KIND_BEYOND, h, sq);
                end
            end
            foreach (batch[i])
            begin
                r = batch[i];
                r.last = (i == batch.size() - 1);
                due_results = {due_results, r};
            end
        endfunction

        function void check_result(input logic [KB-1:0] k, input logic [HB-1:0] h,
                                   input logic [SB-1:0] s, input logic l);
            result_t want;
            results_seen++;
            if (k <= iodrb_pkg::KIND_BEYOND)
            begin
                kind_tally[k]++;
            end
            if (due_results.size() == 0)
            begin
                flag($sformatf("unexpected result kind=%0d handle=%h seq=%h last=%b",
                               k, h, s, l));
                return;
            end
            want = due_results.pop_front();
            if (want.kind !== k || want.handle !== h || want.seq !== s || want.last !== l)
            begin
                flag($sformatf({"mismatch: expected kind=%0d handle=%h seq=%h last=%b, ",
                                "got kind=%0d handle=%h seq=%h last=%b"},
                               want.kind, want.handle, want.seq, want.last, k, h, s, l));
            end
        endfunction

        function void settle();
            if (due_results.size() != 0)
            begin
                flag($sformatf("%0d expected results never arrived", due_results.size()));
            end
        endfunction
    endclass

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          reliable = 1'b0;
    logic [SB-1:0] seq_num = '0;
    logic [HB-1:0] payload_handle = '0;
    logic          busy;
    logic          strobe;
    logic [KB-1:0] kind;
    logic [HB-1:0] out_handle;
    logic [SB-1:0] out_seq;
    logic          last;

    delivery_scoreboard book;
    bit                 steady = 1'b0;
    int                 sent = 0;

    in_order_delivery_reorder_buffer_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .reliable       (reliable),
        .seq_num        (seq_num),
        .payload_handle (payload_handle),
        .strobe         (strobe),
        .kind           (kind),
        .out_handle     (out_handle),
        .out_seq        (out_seq),
        .last           (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            book.check_result(kind, out_handle, out_seq, last);
        end
    end

    function automatic logic [HB-1:0] rand_handle();
        logic [HB-1:0] h;
        case ($urandom_range(0, 15))
            0:       h = '0;
            1:       h = '1;
            default: h = HB'($urandom);
        endcase
        return h;
    endfunction

    task automatic send_message(input logic rel, input logic [SB-1:0] sq,
                                input logic [HB-1:0] h);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        reliable <= rel;
        seq_num <= sq;
        payload_handle <= h;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        book.note_request(rel, sq, h);
        sent++;
    endtask

    // Send a run of consecutive numbers out of order, with holes and re-sends.
    task automatic reorder_run();
        logic [SB-1:0] base;
        logic [SB-1:0] hold;
        logic [SB-1:0] order [$];
        int            span;
        int            pick;
        int            head;
        base = book.last_seq;
        span = ($urandom_range(0, 5) == 0) ? W : $urandom_range(1, 8);
        for (int i = 1; i <= span; i++)
        begin
            order = {order, base + SB'(i)};
        end
        for (int i = order.size() - 1; i > 0; i--)
        begin
            pick = $urandom_range(0, i);
            hold = order[i];
            order[i] = order[pick];
            order[pick] = hold;
        end
        head = 0;
        foreach (order[i])
        begin
            if (order[i] == base + 1'b1)
            begin
                head = i;
            end
        end
        if ($urandom_range(0, 9) == 0)
        begin
            order.delete(head);
        end
        else if (span == W ? $urandom_range(0, 1) == 0 : $urandom_range(0, 2) == 0)
        begin
            hold = order[head];
            order.delete(head);
            order = {order, hold};
        end
        if (order.size() > 0 && $urandom_range(0, 3) == 0)
        begin
            hold = order[$urandom_range(0, order.size() - 1)];
            order = {order, hold};
        end
        foreach (order[i])
        begin
            send_message(1'b1, order[i], rand_handle());
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int choice;
        int waited;
        book = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_message(1'b0, 16'hFFFF, '1);
        send_message(1'b0, 16'h0000, '0);
        send_message(1'b1, 16'h0000, rand_handle());
        send_message(1'b1, 16'h0001, rand_handle());
        send_message(1'b1, 16'h0003, rand_handle());
        send_message(1'b1, 16'h0003, rand_handle());
        send_message(1'b1, SB'(1 + W), rand_handle());
        send_message(1'b1, SB'(2 + W), rand_handle());
        send_message(1'b1, 16'h8001, rand_handle());
        send_message(1'b1, 16'h8000, rand_handle());
        send_message(1'b1, 16'hFFFF, rand_handle());
        send_message(1'b1, 16'h0002, rand_handle());
        send_message(1'b1, SB'(1 + W), rand_handle());
        send_message(1'b1, 16'h0005, rand_handle());
        send_message(1'b1, 16'h0004, rand_handle());
        send_message(1'b1, 16'h0006, '0);
        send_message(1'b1, 16'h0007, '1);
        send_message(1'b0, SB'($urandom), rand_handle());

        while (sent < 430)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                steady = !steady;
            end
            choice = $urandom_range(0, 99);
            if (choice < 55)
            begin
                reorder_run();
            end
            else if (choice < 67)
            begin
                send_message(1'b0, SB'($urandom), rand_handle());
            end
            else if (choice < 77)
            begin
                send_message(1'b1, book.last_seq - SB'($urandom_range(0, 'h8000)),
                             rand_handle());
            end
            else if (choice < 85)
            begin
                send_message(1'b1, book.last_seq + SB'($urandom_range(W + 1, 'h7FFF)),
                             rand_handle());
            end
            else if (choice < 93)
            begin
                case ($urandom_range(0, 4))
                    0: send_message(1'b1, book.last_seq + SB'(W), rand_handle());
                    1: send_message(1'b1, book.last_seq + SB'(W + 1), rand_handle());
                    2: send_message(1'b1, book.last_seq + 16'h8000, rand_handle());
                    3: send_message(1'b1, book.last_seq + 16'h7FFF, rand_handle());
                    default: send_message(1'b1, book.last_seq + 2'd2, rand_handle());
                endcase
            end
            else
            begin
                send_message(1'b1, SB'($urandom), rand_handle());
            end
        end
        start <= 1'b0;

        waited = 0;
        while (book.due_results.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
        book.settle();

        $display("%0d requests, %0d results: unreliable %0d, delivered %0d, duplicate %0d,",
                 book.requests, book.results_seen, book.kind_tally[iodrb_pkg::KIND_UNREL],
                 book.kind_tally[iodrb_pkg::KIND_DELIV], book.kind_tally[iodrb_pkg::KIND_DUP]);
        $display("parked %0d, beyond window %0d; longest release run %0d, faults %0d",
                 book.kind_tally[iodrb_pkg::KIND_BUF],
                 book.kind_tally[iodrb_pkg::KIND_BEYOND], book.longest_run, book.faults);
        if (book.faults == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
